/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by midpoint_odometry_integrator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
	else $error("forbidden condition");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

/* sv/moi_pkg.sv */
// ----------------------------------------------------------------------------
// moi_pkg
// Shared constants, codes and helpers for the odometry integrator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package moi_pkg;
	localparam logic signed [33:0] PI_Q      = 34'sd843314857;
	localparam logic signed [33:0] TWO_PI_Q  = 34'sd1686629714;
	localparam logic signed [33:0] HALF_PI_Q = 34'sd421657428;
	localparam logic signed [33:0] CORDIC_K  = 34'sd652032874;

	localparam logic [1:0] KIND_TICK    = 2'd0;
	localparam logic [1:0] KIND_SET     = 2'd1;
	localparam logic [1:0] KIND_REBASE  = 2'd2;

	localparam logic [1:0] CFG_LSE = 2'd0;
	localparam logic [1:0] CFG_ASE = 2'd1;
	localparam logic [1:0] CFG_LD  = 2'd2;
	localparam logic [1:0] CFG_YD  = 2'd3;

	// atan(2^-i) in Q4.28
	function automatic logic signed [33:0] atan_q(input logic [4:0] i);
		case (i)
			5'd0:  return 34'sd210828714;
			5'd1:  return 34'sd124459457;
			5'd2:  return 34'sd65760959;
			5'd3:  return 34'sd33381290;
			5'd4:  return 34'sd16755422;
			5'd5:  return 34'sd8385879;
			5'd6:  return 34'sd4193963;
			5'd7:  return 34'sd2097109;
			5'd8:  return 34'sd1048571;
			5'd9:  return 34'sd524287;
			5'd10: return 34'sd262144;
			5'd11: return 34'sd131072;
			5'd12: return 34'sd65536;
			5'd13: return 34'sd32768;
			5'd14: return 34'sd16384;
			5'd15: return 34'sd8192;
			5'd16: return 34'sd4096;
			5'd17: return 34'sd2048;
			5'd18: return 34'sd1024;
			5'd19: return 34'sd512;
			5'd20: return 34'sd256;
			5'd21: return 34'sd128;
			5'd22: return 34'sd64;
			5'd23: return 34'sd32;
			5'd24: return 34'sd16;
			5'd25: return 34'sd8;
			5'd26: return 34'sd4;
			5'd27: return 34'sd2;
			5'd28: return 34'sd1;
			default: return 34'sd0;
		endcase
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
		if (v > 72'sd2147483647) return 32'sh7fffffff;
		if (v < -72'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// halve, truncating toward zero
	function automatic logic signed [33:0] half_tz(input logic signed [33:0] v);
		logic signed [33:0] t;
		t = v + {33'd0, v[33]};
		return t >>> 1;
	endfunction
endpackage
`default_nettype wire

/* sv/moi_cordic.sv */
// ----------------------------------------------------------------------------
// moi_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module moi_cordic #(
	parameter int ITERATIONS = 24
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	input  wire logic signed [31:0]  angle,
	output logic                     done,
	output logic signed [33:0]       cos_o,
	output logic signed [33:0]       sin_o
);
	import moi_pkg::*;
	localparam int CW = $clog2(ITERATIONS);

	logic              busy_q, flip_q;
	logic [CW-1:0]     cnt_q;
	logic signed [33:0] x_q, y_q, z_q, xs, ys, at;
	logic signed [33:0] zin;

	assign zin = 34'(angle);
	assign xs  = x_q >>> cnt_q;
	assign ys  = y_q >>> cnt_q;
	assign at  = atan_q(5'(cnt_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				x_q    <= CORDIC_K;
				y_q    <= '0;
				if (zin > HALF_PI_Q) begin
					z_q <= zin - PI_Q; flip_q <= 1'b1;
				end else if (zin < -HALF_PI_Q) begin
					z_q <= zin + PI_Q; flip_q <= 1'b1;
				end else begin
					z_q <= zin; flip_q <= 1'b0;
				end
			end else if (busy_q) begin
				if (z_q >= 0) begin
					x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - at;
				end else begin
					x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + at;
				end
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(ITERATIONS - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign cos_o = flip_q ? -x_q : x_q;
	assign sin_o = flip_q ? -y_q : y_q;
endmodule
`default_nettype wire

/* sv/moi_div.sv */
// ----------------------------------------------------------------------------
// moi_div
// Restoring signed-by-unsigned divider, one quotient bit per cycle,
// truncating toward zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module moi_div (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	input  wire logic signed [42:0]  num,
	input  wire logic [31:0]         den,
	output logic                     done,
	output logic signed [43:0]       quo
);
	logic        busy_q, neg_q;
	logic [5:0]  cnt_q;
	logic [31:0] den_q, rem_q;
	logic [42:0] qm_q;
	logic [32:0] rem_sh, rem_sub;

	assign rem_sh  = {rem_q, qm_q[42]};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				neg_q  <= num[42];
				qm_q   <= num[42] ? 43'(-num) : 43'(num);
				rem_q  <= '0;
				den_q  <= den;
			end else if (busy_q) begin
				if (rem_sh >= {1'b0, den_q}) begin
					rem_q <= rem_sub[31:0];
					qm_q  <= {qm_q[41:0], 1'b1};
				end else begin
					rem_q <= rem_sh[31:0];
					qm_q  <= {qm_q[41:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'd42) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign quo = neg_q ? -$signed({1'b0, qm_q}) : $signed({1'b0, qm_q});
endmodule
`default_nettype wire

/* sv/midpoint_odometry_integrator.sv */
// ----------------------------------------------------------------------------
// midpoint_odometry_integrator
// Dead-reckoning pose estimator with midpoint-arc integration.
// ----------------------------------------------------------------------------
// Usage:
//  Input word (in_valid/in_stall): kind, time_ms, true pose, set-pose values.
//  Output word (out_valid/out_stall): current estimate, speed, rate, baseline
//  flag and last tick time. Exactly one output word per input word.
//  Config: cfg_we/cfg_idx/cfg_wdata, write only while the block is idle.
//  Response: set pose, rebaseline, baseline ticks, zero-dt ticks and unknown
//  kinds answer in the cycle after acceptance. An integrating tick runs two
//  CORDIC rotations, eight products (each two passes through one 19x36
//  multiplier and a result step), one setup step, four angle wraps, and two
//  divisions for speed and rate.
//  One word is in flight at a time; in_stall is high from acceptance until
//  the output word is taken.
//  A stalled output word holds; no new input is taken meanwhile.
//  Reset clears the estimate, baseline, rates and config registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module midpoint_odometry_integrator #(
	parameter int CORDIC_ITERATIONS = 24
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_stall,
	input  wire logic [1:0]          kind,
	input  wire logic [31:0]         time_ms,
	input  wire logic signed [31:0]  true_x,
	input  wire logic signed [31:0]  true_y,
	input  wire logic signed [30:0]  true_heading,
	input  wire logic signed [31:0]  new_x,
	input  wire logic signed [31:0]  new_y,
	input  wire logic signed [30:0]  new_heading,
	output logic                     out_valid,
	input  wire                      out_stall,
	output logic signed [31:0]       est_x,
	output logic signed [31:0]       est_y,
	output logic signed [30:0]       est_heading,
	output logic signed [31:0]       forward_speed,
	output logic signed [31:0]       turn_rate,
	output logic                     stamp_valid,
	output logic [31:0]              last_update_ms,
	input  wire                      cfg_we,
	input  wire logic [1:0]          cfg_idx,
	input  wire logic [29:0]         cfg_wdata
);
	import moi_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_WRAP, ST_CORD, ST_MUL0, ST_MUL1, ST_MRES, ST_SC2, ST_DIV
	} state_t;
	typedef enum logic [1:0] { W_DTH, W_SC1, W_SC2, W_ODOH } wsel_t;
	typedef enum logic [2:0] { M_DX, M_DY, M_A, M_H, M_OX, M_OY, M_SP, M_RT } mop_t;

	state_t state_q;
	wsel_t  wsel_q;
	mop_t   mop_q;

	// config
	logic signed [17:0] lse_q, ase_q, ld_q;
	logic signed [29:0] yd_q;

	// model state
	logic signed [31:0] prev_x_q, prev_y_q, odo_x_q, odo_y_q, speed_q, rate_q;
	logic signed [30:0] prev_h_q, odo_h_q;
	logic               base_q;
	logic [31:0]        last_q;
	logic               out_valid_q;

	// working registers
	logic signed [31:0] tx_q, ty_q, a_q, h_q;
	logic signed [30:0] th_q, dth_q;
	logic [31:0]        dt_q;
	logic signed [33:0] w_q, c_q, s_q;
	logic signed [35:0] arc_q;
	logic signed [71:0] prod_q;
	logic signed [31:0] cang_q;
	logic               cstart_q, dstart_q;
	logic signed [42:0] dnum_q;

	// angle wrap step
	logic               w_big_pos, w_big_neg;
	logic signed [33:0] wf;
	assign w_big_pos = (w_q >= TWO_PI_Q);
	assign w_big_neg = (w_q <= -TWO_PI_Q);
	assign wf = (w_q > PI_Q) ? w_q - TWO_PI_Q :
	            (w_q <= -PI_Q) ? w_q + TWO_PI_Q : w_q;

	// shared multiplier, two passes: low 18 bits of A, then high part
	logic signed [35:0] mul_a, mul_b;
	logic signed [18:0] m_op;
	logic signed [54:0] mp;
	logic signed [32:0] dx, dy;
	logic signed [71:0] r30, r16;

	assign dx = 33'(tx_q) - 33'(prev_x_q);
	assign dy = 33'(ty_q) - 33'(prev_y_q);

	always_comb begin
		case (mop_q)
			M_DX:    begin mul_a = 36'(dx);    mul_b = 36'(c_q); end
			M_DY:    begin mul_a = 36'(dy);    mul_b = 36'(s_q); end
			M_A:     begin mul_a = arc_q;      mul_b = 36'(19'sd65536 + 19'(lse_q)); end
			M_H:     begin mul_a = 36'(dth_q); mul_b = 36'(19'sd65536 + 19'(ase_q)); end
			M_OX:    begin mul_a = 36'(a_q);   mul_b = 36'(c_q); end
			M_OY:    begin mul_a = 36'(a_q);   mul_b = 36'(s_q); end
			M_SP:    begin mul_a = 36'(a_q);   mul_b = 36'sd1000; end
			M_RT:    begin mul_a = 36'(h_q);   mul_b = 36'sd1000; end
			default: begin mul_a = '0;         mul_b = '0; end
		endcase
	end

	assign m_op = (state_q == ST_MUL0) ? $signed({1'b0, mul_a[17:0]})
	                                   : $signed({mul_a[35], mul_a[35:18]});
	assign mp   = m_op * mul_b;
	assign r30  = (prod_q + (72'sd1 <<< 29)) >>> 30;
	assign r16  = (prod_q + (72'sd1 <<< 15)) >>> 16;

	// shared iterative units
	logic               c_done, d_done;
	logic signed [33:0] c_cos, c_sin;
	logic signed [43:0] d_quo;

	moi_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cstart_q), .angle(cang_q),
		.done(c_done), .cos_o(c_cos), .sin_o(c_sin)
	);

	moi_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart_q), .num(dnum_q), .den(dt_q),
		.done(d_done), .quo(d_quo)
	);

	logic        accept;
	logic [31:0] dt_new;
	assign accept = in_valid && !in_stall;
	assign dt_new = time_ms - last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wsel_q      <= W_DTH;
			mop_q       <= M_DX;
			lse_q       <= '0;
			ase_q       <= '0;
			ld_q        <= '0;
			yd_q        <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_h_q    <= '0;
			odo_x_q     <= '0;
			odo_y_q     <= '0;
			odo_h_q     <= '0;
			speed_q     <= '0;
			rate_q      <= '0;
			base_q      <= 1'b0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
			cstart_q    <= 1'b0;
			dstart_q    <= 1'b0;
		end else begin
			cstart_q <= 1'b0;
			dstart_q <= 1'b0;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_idx)
					CFG_LSE: lse_q <= cfg_wdata[17:0];
					CFG_ASE: ase_q <= cfg_wdata[17:0];
					CFG_LD:  ld_q  <= cfg_wdata[17:0];
					CFG_YD:  yd_q  <= cfg_wdata;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						tx_q <= true_x;
						ty_q <= true_y;
						th_q <= true_heading;
						// integrating ticks answer once the sequence is done
						out_valid_q <= !(kind == KIND_TICK && base_q && dt_new != 32'd0);
						case (kind)
							KIND_TICK: begin
								if (!base_q) begin
									base_q   <= 1'b1;
									last_q   <= time_ms;
									prev_x_q <= true_x;
									prev_y_q <= true_y;
									prev_h_q <= true_heading;
								end else begin
									last_q <= time_ms;
									dt_q   <= dt_new;
									if (dt_new != 32'd0) begin
										w_q     <= 34'(true_heading) - 34'(prev_h_q);
										wsel_q  <= W_DTH;
										state_q <= ST_WRAP;
									end
								end
							end
							KIND_SET: begin
								odo_x_q <= new_x;
								odo_y_q <= new_y;
								odo_h_q <= new_heading;
							end
							KIND_REBASE: base_q <= 1'b0;
							default: ;
						endcase
					end
				end
				ST_WRAP: begin
					if (w_big_pos) w_q <= w_q - TWO_PI_Q;
					else if (w_big_neg) w_q <= w_q + TWO_PI_Q;
					else begin
						case (wsel_q)
							W_DTH: begin
								dth_q  <= 31'(wf);
								w_q    <= 34'(prev_h_q) + half_tz(wf);
								wsel_q <= W_SC1;
							end
							W_SC1, W_SC2: begin
								cang_q   <= 32'(wf);
								cstart_q <= 1'b1;
								state_q  <= ST_CORD;
							end
							W_ODOH: begin
								odo_h_q <= 31'(wf);
								mop_q   <= M_SP;
								state_q <= ST_MUL0;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CORD: begin
					if (c_done) begin
						c_q     <= c_cos;
						s_q     <= c_sin;
						mop_q   <= (wsel_q == W_SC1) ? M_DX : M_OX;
						state_q <= ST_MUL0;
					end
				end
				ST_MUL0: begin
					prod_q  <= 72'(mp);
					state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					prod_q  <= prod_q + (72'(mp) <<< 18);
					state_q <= ST_MRES;
				end
				ST_MRES: begin
					state_q <= ST_MUL0;
					case (mop_q)
						M_DX: begin
							arc_q <= 36'(r30);
							mop_q <= M_DY;
						end
						M_DY: begin
							arc_q    <= arc_q + 36'(r30);
							prev_x_q <= tx_q;
							prev_y_q <= ty_q;
							prev_h_q <= th_q;
							mop_q    <= M_A;
						end
						M_A: begin
							a_q   <= sat32(r16);
							mop_q <= M_H;
						end
						M_H: begin
							h_q     <= sat32(r16);
							state_q <= ST_SC2;
						end
						M_OX: begin
							odo_x_q <= sat32(72'(odo_x_q) + r30 + 72'(ld_q));
							mop_q   <= M_OY;
						end
						M_OY: begin
							odo_y_q <= sat32(72'(odo_y_q) + r30);
							w_q     <= 34'(odo_h_q) + 34'(h_q) + 34'(yd_q);
							wsel_q  <= W_ODOH;
							state_q <= ST_WRAP;
						end
						M_SP, M_RT: begin
							dnum_q   <= 43'(prod_q);
							dstart_q <= 1'b1;
							state_q  <= ST_DIV;
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_SC2: begin
					w_q     <= 34'(odo_h_q) + half_tz(34'(h_q));
					wsel_q  <= W_SC2;
					state_q <= ST_WRAP;
				end
				ST_DIV: begin
					if (d_done) begin
						if (mop_q == M_SP) begin
							speed_q <= sat32(72'(d_quo));
							mop_q   <= M_RT;
							state_q <= ST_MUL0;
						end else begin
							rate_q      <= sat32(72'(d_quo));
							out_valid_q <= 1'b1;
							state_q     <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall       = (state_q != ST_IDLE) || out_valid_q;
	assign out_valid      = out_valid_q;
	assign est_x          = odo_x_q;
	assign est_y          = odo_y_q;
	assign est_heading    = odo_h_q;
	assign forward_speed  = speed_q;
	assign turn_rate      = rate_q;
	assign stamp_valid    = base_q;
	assign last_update_ms = last_q;

	`ASSERT_CLK(a_first_tick_sets_base, clk, arst_n,
		in_valid && !in_stall && kind == KIND_TICK && !stamp_valid |=> stamp_valid)
	`ASSERT_CLK(a_rebase_clears, clk, arst_n,
		in_valid && !in_stall && kind == KIND_REBASE |=> !stamp_valid)
	`ASSERT_CLK(a_set_pose_x, clk, arst_n,
		in_valid && !in_stall && kind == KIND_SET |=> est_x == $past(new_x))
	`ASSERT_CLK(a_time_only_on_tick, clk, arst_n,
		in_valid && !in_stall && kind != KIND_TICK |=> $stable(last_update_ms))
endmodule
`default_nettype wire
